@@ hw/rtl/dtf_pkg.sv @@
package dtf_pkg;

  // Operation codes carried by the operation field of an input item.
  localparam logic [1:0] OP_UPDATE  = 2'd0;
  localparam logic [1:0] OP_EVAL    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PROP_GAIN = 2'd0;
  localparam logic [1:0] CFG_FREQ_GAIN = 2'd1;
  localparam logic [1:0] CFG_NOM_PER   = 2'd2;

  // Fixed formats.
  localparam int TIME_W      = 64;
  localparam int PERIOD_W    = 48;
  localparam int PERIOD_FRAC = 48;
  localparam int GAIN_W      = 32;
  localparam int SCOUNT_W    = 16;
  localparam int OFFSET_W    = 32;
  localparam int CFG_W       = 48;

  // Accumulator of the shared multiplier: 64 x 32 product plus the rounding bit.
  localparam int ACC_W = TIME_W + GAIN_W + 1;

endpackage

@@ hw/rtl/dll_timestamp_filter_unit.sv @@
// An update item runs the prediction multiply, the error, the radix-2 reciprocal divider
// and the correction and period multiplies before its result; the first update after a
// restart goes straight to its result, an evaluate item runs one multiply and add, and a
// restart gives no result. One item is in work at a time: the block returns to idle as
// the result is written to the output register, and only then takes the next item.
// Reset clears the estimate, the period, the update count and all configuration registers.
module dll_timestamp_filter_unit import dtf_pkg::*; #(
  parameter int COUNT_WIDTH    = 16,
  parameter int TIME_FRAC_BITS = 24,
  parameter int GAIN_FRAC_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  // Input item channel.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 operation_i,
  input  logic [TIME_W-1:0]          raw_time_i,
  input  logic [SCOUNT_W-1:0]        sample_count_i,
  input  logic signed [OFFSET_W-1:0] eval_offset_i,
  // Result item channel.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [TIME_W-1:0]          time_estimate_o
);

  // Shift amounts of the three scaled products.
  localparam int SH_ADV = PERIOD_FRAC - TIME_FRAC_BITS;  // period * samples -> time
  localparam int SH_COR = GAIN_FRAC_BITS;                // error * phase gain
  localparam int SH_PER = TIME_FRAC_BITS;                // error * frequency gain

  localparam logic [ACC_W-1:0] RND_ADV = ACC_W'(1) << (SH_ADV - 1);
  localparam logic [ACC_W-1:0] RND_COR = ACC_W'(1) << (SH_COR - 1);
  localparam logic [ACC_W-1:0] RND_PER = ACC_W'(1) << (SH_PER - 1);

  // The reciprocal divider works on a dividend of 2^GAIN_FRAC_BITS plus half the count.
  localparam int DIVW  = (GAIN_FRAC_BITS + 1 > COUNT_WIDTH) ? GAIN_FRAC_BITS + 1 : COUNT_WIDTH;
  localparam int DCNTW = $clog2(DIVW);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [PERIOD_W-1:0]    PER_MAX   = {PERIOD_W{1'b1}};

  // Sequencer states. Every "_M" state runs the shared multiplier through its steps and
  // every "_A" state passes its product through the shared saturating adder.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADV_M  = 4'd1;
  localparam logic [3:0] S_PRED   = 4'd2;
  localparam logic [3:0] S_ERR    = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_GAIN   = 4'd5;
  localparam logic [3:0] S_CORR_M = 4'd6;
  localparam logic [3:0] S_CORR_A = 4'd7;
  localparam logic [3:0] S_DPER_M = 4'd8;
  localparam logic [3:0] S_DPER_A = 4'd9;
  localparam logic [3:0] S_EVAL_M = 4'd10;
  localparam logic [3:0] S_EVAL_A = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  // Control state.
  logic [3:0]             state_q;
  logic [1:0]             mstep_q;
  logic [DCNTW-1:0]       div_cnt_q;
  logic                   out_valid_q;

  // Loop state and configuration.
  logic [TIME_W-1:0]      est_q;
  logic [PERIOD_W-1:0]    period_q;
  logic [COUNT_WIDTH-1:0] upd_cnt_q;
  logic [GAIN_W-1:0]      prop_gain_q;
  logic [GAIN_W-1:0]      freq_gain_q;

  // Working registers of one item.
  logic [TIME_W-1:0]      raw_q;
  logic [SCOUNT_W-1:0]    scnt_q;
  logic [OFFSET_W-1:0]    off_mag_q;
  logic                   neg_q;
  logic [TIME_W-1:0]      pred_q;
  logic [TIME_W-1:0]      mag_q;
  logic [GAIN_W-1:0]      gain_q;
  logic [63:0]            prod_q;
  logic [ACC_W-1:0]       acc_q;
  logic [COUNT_WIDTH-1:0] rem_q;
  logic [DIVW-1:0]        quo_q;
  logic [TIME_W-1:0]      time_estimate_q;

  logic in_accept;
  logic out_free;
  assign in_accept = in_valid_i && (state_q == S_IDLE);
  // The output register can take a new result when it is empty or being drained.
  assign out_free  = !out_valid_q || !out_stall_i;

  // Count as it stands after an update item is applied; it stops at its maximum.
  logic [COUNT_WIDTH-1:0] upd_cnt_d;
  assign upd_cnt_d = (upd_cnt_q == COUNT_MAX) ? upd_cnt_q : upd_cnt_q + COUNT_WIDTH'(1);

  // Evaluate offset as sign and magnitude; the most negative offset gives 2^31.
  logic [OFFSET_W-1:0] off_mag_d;
  assign off_mag_d = eval_offset_i[OFFSET_W-1] ? OFFSET_W'(-eval_offset_i)
                                                : OFFSET_W'(eval_offset_i);

  // ---------------------------------------------------------------------------
  // Shared multiplier: a 64-bit operand times a 32-bit operand in two 32 x 32 halves.
  // Step 0 forms the low partial product, step 1 seeds the accumulator with it plus the
  // rounding constant while forming the high partial product, step 2 adds the high one.
  // ---------------------------------------------------------------------------
  logic [63:0]      mul_a;
  logic [31:0]      mul_b;
  logic [ACC_W-1:0] mul_rnd;
  logic [31:0]      mul_half;
  logic [63:0]      prod_d;

  always_comb begin
    case (state_q)
      S_CORR_M: begin
        mul_a   = mag_q;
        mul_b   = gain_q;
        mul_rnd = RND_COR;
      end
      S_DPER_M: begin
        mul_a   = mag_q;
        mul_b   = freq_gain_q;
        mul_rnd = RND_PER;
      end
      S_EVAL_M: begin
        mul_a   = 64'(period_q);
        mul_b   = off_mag_q;
        mul_rnd = RND_ADV;
      end
      default: begin
        mul_a   = 64'(period_q);
        mul_b   = 32'(scnt_q);
        mul_rnd = RND_ADV;
      end
    endcase
  end

  assign mul_half = (mstep_q == 2'd0) ? mul_a[31:0] : mul_a[63:32];
  assign prod_d   = mul_half * mul_b;

  // Rounded, shifted and saturated product, read in the state after each multiply.
  logic [TIME_W-1:0] mul_res;
  logic [TIME_W-1:0] ext_adv, ext_cor, ext_per;
  logic              ovf_adv, ovf_cor, ovf_per;

  assign ext_adv = 64'(acc_q >> SH_ADV);
  assign ext_cor = 64'(acc_q >> SH_COR);
  assign ext_per = 64'(acc_q >> SH_PER);
  assign ovf_adv = |(acc_q >> (SH_ADV + TIME_W));
  assign ovf_cor = |(acc_q >> (SH_COR + TIME_W));
  assign ovf_per = |(acc_q >> (SH_PER + TIME_W));

  always_comb begin
    case (state_q)
      S_CORR_A: mul_res = ovf_cor ? {TIME_W{1'b1}} : ext_cor;
      S_DPER_A: mul_res = ovf_per ? {TIME_W{1'b1}} : ext_per;
      default:  mul_res = ovf_adv ? {TIME_W{1'b1}} : ext_adv;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared saturating adder: base plus or minus the product, clamped to zero below and
  // to either the full time range or the period range above.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] add_base;
  logic              add_neg;
  logic              add_lim_per;
  logic [TIME_W:0]   add_sum;
  logic [TIME_W:0]   add_dif;
  logic [TIME_W-1:0] add_res;

  always_comb begin
    case (state_q)
      S_PRED: begin
        add_base    = est_q;
        add_neg     = 1'b0;
        add_lim_per = 1'b0;
      end
      S_CORR_A: begin
        add_base    = pred_q;
        add_neg     = neg_q;
        add_lim_per = 1'b0;
      end
      S_DPER_A: begin
        add_base    = 64'(period_q);
        add_neg     = neg_q;
        add_lim_per = 1'b1;
      end
      default: begin
        add_base    = est_q;
        add_neg     = neg_q;
        add_lim_per = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_base} + {1'b0, mul_res};
  assign add_dif = {1'b0, add_base} - {1'b0, mul_res};

  always_comb begin
    if (add_neg) begin
      add_res = add_dif[TIME_W] ? '0 : add_dif[TIME_W-1:0];
    end else if (add_lim_per) begin
      add_res = (|add_sum[TIME_W:PERIOD_W]) ? 64'(PER_MAX) : add_sum[TIME_W-1:0];
    end else begin
      add_res = add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0];
    end
  end

  // Prediction error as sign and magnitude.
  logic [TIME_W:0]   err_dif;
  logic [TIME_W-1:0] err_mag;
  assign err_dif = {1'b0, raw_q} - {1'b0, pred_q};
  assign err_mag = err_dif[TIME_W] ? pred_q - raw_q : err_dif[TIME_W-1:0];

  // ---------------------------------------------------------------------------
  // Restoring divider for the 1/count gain, one quotient bit per cycle. The dividend is
  // shifted out of the top of the quotient register as quotient bits enter at the bottom.
  // ---------------------------------------------------------------------------
  logic [DIVW-1:0]        div_dividend;
  logic [COUNT_WIDTH:0]   div_trial;
  logic                   div_ge;
  logic [COUNT_WIDTH:0]   div_sub;
  logic [COUNT_WIDTH-1:0] rem_d;

  assign div_dividend = (DIVW'(1) << GAIN_FRAC_BITS) + DIVW'(upd_cnt_q >> 1);
  assign div_trial    = {rem_q, quo_q[DIVW-1]};
  assign div_ge       = div_trial >= {1'b0, upd_cnt_q};
  assign div_sub      = div_trial - {1'b0, upd_cnt_q};
  assign rem_d        = div_ge ? div_sub[COUNT_WIDTH-1:0] : div_trial[COUNT_WIDTH-1:0];

  // Loop gain: the larger of the phase gain and the rounded reciprocal of the count.
  logic [GAIN_W-1:0] inv_gain;
  logic              inv_sat;
  logic [GAIN_W-1:0] gain_d;
  assign inv_gain = GAIN_W'(quo_q);
  assign inv_sat  = 64'(quo_q) > 64'({GAIN_W{1'b1}});
  assign gain_d   = inv_sat ? {GAIN_W{1'b1}}
                  : ((prop_gain_q > inv_gain) ? prop_gain_q : inv_gain);

  // ---------------------------------------------------------------------------
  // Sequencer and loop state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mstep_q     <= 2'd0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      est_q       <= '0;
      period_q    <= '0;
      upd_cnt_q   <= '0;
      prop_gain_q <= '0;
      freq_gain_q <= '0;
    end else begin
      // The output register fills when a result is ready and empties when it is taken.
      if (out_free && (state_q inside {S_OUT, S_EVAL_A})) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PROP_GAIN: prop_gain_q <= cfg_wdata_i[GAIN_W-1:0];
          CFG_FREQ_GAIN: freq_gain_q <= cfg_wdata_i[GAIN_W-1:0];
          CFG_NOM_PER:   period_q    <= cfg_wdata_i[PERIOD_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (operation_i)
              OP_UPDATE: begin
                upd_cnt_q <= upd_cnt_d;
                if (upd_cnt_d == COUNT_WIDTH'(1)) begin
                  // First update after a restart loads the estimate as measured.
                  est_q   <= raw_time_i;
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_ADV_M;
                end
              end
              OP_EVAL:    state_q   <= S_EVAL_M;
              OP_RESTART: upd_cnt_q <= '0;
              default: ;
            endcase
          end
        end
        S_ADV_M, S_CORR_M, S_DPER_M, S_EVAL_M: begin
          if (mstep_q == 2'd2) begin
            mstep_q <= 2'd0;
            case (state_q)
              S_ADV_M:  state_q <= S_PRED;
              S_CORR_M: state_q <= S_CORR_A;
              S_DPER_M: state_q <= S_DPER_A;
              default:  state_q <= S_EVAL_A;
            endcase
          end else begin
            mstep_q <= mstep_q + 2'd1;
          end
        end
        S_PRED: state_q <= S_ERR;
        S_ERR: begin
          div_cnt_q <= DCNTW'(DIVW - 1);
          state_q   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt_q == '0) begin
            state_q <= S_GAIN;
          end else begin
            div_cnt_q <= div_cnt_q - DCNTW'(1);
          end
        end
        S_GAIN: state_q <= S_CORR_M;
        S_CORR_A: begin
          est_q   <= add_res;
          state_q <= S_DPER_M;
        end
        S_DPER_A: begin
          period_q <= add_res[PERIOD_W-1:0];
          state_q  <= S_OUT;
        end
        S_EVAL_A: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working registers; they carry no reset since the sequencer qualifies every use.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q     <= raw_time_i;
      scnt_q    <= sample_count_i;
      off_mag_q <= off_mag_d;
      neg_q     <= eval_offset_i[OFFSET_W-1];
    end

    case (state_q)
      S_ADV_M, S_CORR_M, S_DPER_M, S_EVAL_M: begin
        prod_q <= prod_d;
        if (mstep_q == 2'd1) begin
          acc_q <= ACC_W'(prod_q) + mul_rnd;
        end else if (mstep_q == 2'd2) begin
          acc_q <= acc_q + (ACC_W'(prod_q) << 32);
        end
      end
      S_PRED: pred_q <= add_res;
      S_ERR: begin
        neg_q <= err_dif[TIME_W];
        mag_q <= err_mag;
        rem_q <= '0;
        quo_q <= div_dividend;
      end
      S_DIV: begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DIVW-2:0], div_ge};
      end
      S_GAIN: gain_q <= gain_d;
      S_EVAL_A: begin
        if (out_free) begin
          time_estimate_q <= add_res;
        end
      end
      S_OUT: begin
        if (out_free) begin
          time_estimate_q <= est_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign time_estimate_o = time_estimate_q;

endmodule

@@ tb/testbench.sv @@
module testbench;
  import dtf_pkg::*;

  // The operation field has one code that the block ignores without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam logic [63:0]       PERIOD_MAX = (64'd1 << PERIOD_W) - 64'd1;
  localparam int                TIME_FRAC  = 24;
  localparam int                GAIN_FRAC  = 32;
  localparam int                LOOP_CNT_W = 16;
  localparam logic [LOOP_CNT_W-1:0] LOOP_CNT_MAX = '1;

  // Settle time after the last estimate is back, so any item still in work can finish.
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 142;
  localparam int RANDOM_PHASES = 8;

  // One input item as it is offered to the block.
  typedef struct packed {
    logic [1:0]          kind;
    logic [TIME_W-1:0]   raw;
    logic [SCOUNT_W-1:0] count;
    logic [OFFSET_W-1:0] offset;
  } stamp_item_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       cfg_we_i        = 1'b0;
  logic [1:0]                 cfg_index_i     = CFG_PROP_GAIN;
  logic [CFG_W-1:0]           cfg_wdata_i     = '0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 operation_i     = OP_UPDATE;
  logic [TIME_W-1:0]          raw_time_i      = '0;
  logic [SCOUNT_W-1:0]        sample_count_i  = '0;
  logic signed [OFFSET_W-1:0] eval_offset_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic [TIME_W-1:0]          time_estimate_o;

  dll_timestamp_filter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .raw_time_i      (raw_time_i),
    .sample_count_i  (sample_count_i),
    .eval_offset_i   (eval_offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .time_estimate_o (time_estimate_o)
  );

  always #2 clk_i = ~clk_i;

  // Items waiting to be offered, and the estimates the block still owes us.
  stamp_item_t       queued_stamps[$];
  logic [TIME_W-1:0] due_estimates[$];

  // Our own copy of the loop state and of the configuration registers.
  logic [GAIN_W-1:0]     phase_gain  = '0;
  logic [GAIN_W-1:0]     freq_gain   = '0;
  logic [PERIOD_W-1:0]   period_est  = '0;
  logic [TIME_W-1:0]     time_est    = '0;
  logic [LOOP_CNT_W-1:0] loop_count  = '0;

  // Knobs the stimulus process turns per phase; the driver and the stall process read them.
  logic send_gaps_on = 1'b1;
  logic recv_gaps_on = 1'b1;
  logic hold_req     = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;
  int   send_gap     = 0;
  int   stall_run    = 0;

  int n_errors = 0;
  int n_results = 0;
  int n_updates = 0;
  int n_evals = 0;
  int n_restarts = 0;
  int n_unused = 0;
  int n_pred_clamps = 0;
  int n_period_clamps = 0;
  int n_in_stalls = 0;
  int n_settings = 0;

  // round(a * b / 2^s) with halves rounded up, saturated to 64 bits.
  function automatic logic [63:0] scale_round(input logic [63:0] a, input logic [31:0] b,
                                              input int unsigned s);
    logic [127:0] prod;
    prod = {64'd0, a} * {96'd0, b};
    prod = (prod + (128'd1 << (s - 1))) >> s;
    return (prod[127:64] != '0) ? TIME_MAX : prod[63:0];
  endfunction

  // base plus or minus mag, clamped to [0, limit].
  function automatic logic [63:0] nudge_sat(input logic [63:0] base, input logic neg,
                                            input logic [63:0] mag, input logic [63:0] limit);
    if (neg) begin
      return (mag > base) ? 64'd0 : base - mag;
    end
    if (mag > limit - base) begin
      return limit;
    end
    return base + mag;
  endfunction

  // Advances the loop state by one accepted item and queues the estimate it should produce.
  function automatic void track_stamp(input stamp_item_t it);
    logic [63:0] adv, pred, err, recip, gain, corr, dper, mag, shift;
    logic        neg;
    case (it.kind)
      OP_UPDATE: begin
        n_updates++;
        if (loop_count != LOOP_CNT_MAX) begin
          loop_count++;
        end
        if (loop_count == 1) begin
          // First update after a restart simply loads the measured time.
          time_est = it.raw;
        end else begin
          // Predict one interval ahead, then pull both phase and period toward the measurement.
          adv = scale_round({16'd0, period_est}, {16'd0, it.count}, PERIOD_FRAC - TIME_FRAC);
          if (adv > TIME_MAX - time_est) begin
            n_pred_clamps++;
          end
          pred = nudge_sat(time_est, 1'b0, adv, TIME_MAX);
          neg = it.raw < pred;
          err = neg ? pred - it.raw : it.raw - pred;
          recip = ((64'd1 << GAIN_FRAC) + ({48'd0, loop_count} >> 1)) / {48'd0, loop_count};
          gain = ({32'd0, phase_gain} > recip) ? {32'd0, phase_gain} : recip;
          if (gain > 64'hFFFF_FFFF) begin
            gain = 64'hFFFF_FFFF;
          end
          corr = scale_round(err, gain[31:0], GAIN_FRAC);
          time_est = nudge_sat(pred, neg, corr, TIME_MAX);
          dper = scale_round(err, freq_gain, TIME_FRAC);
          if ((neg && dper > {16'd0, period_est}) ||
              (!neg && dper > PERIOD_MAX - {16'd0, period_est})) begin
            n_period_clamps++;
          end
          shift = nudge_sat({16'd0, period_est}, neg, dper, PERIOD_MAX);
          period_est = shift[PERIOD_W-1:0];
        end
        due_estimates.push_back(time_est);
      end
      OP_EVAL: begin
        n_evals++;
        neg = it.offset[OFFSET_W-1];
        mag = neg ? 64'd0 - {{32{it.offset[OFFSET_W-1]}}, it.offset} : {32'd0, it.offset};
        shift = scale_round({16'd0, period_est}, mag[31:0], PERIOD_FRAC - TIME_FRAC);
        due_estimates.push_back(nudge_sat(time_est, neg, shift, TIME_MAX));
      end
      OP_RESTART: begin
        n_restarts++;
        loop_count = '0;
      end
      default: begin
        n_unused++;
      end
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic void queue_stamp(input logic [1:0] kind, input logic [TIME_W-1:0] raw,
                                      input logic [SCOUNT_W-1:0] count,
                                      input logic [OFFSET_W-1:0] offset);
    stamp_item_t it;
    it.kind = kind;
    it.raw = raw;
    it.count = count;
    it.offset = offset;
    queued_stamps.push_back(it);
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("ERROR %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Driver: offers the queued items one at a time. When an item is taken, the loop state
  // copy is advanced right away, so the expected estimate is in place before the result.
  // A stalled item stays on the bus untouched; valid is only ever dropped after acceptance.
  always @(posedge clk_i) begin : stamp_driver
    stamp_item_t it;
    logic        next_valid;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) begin
        n_in_stalls++;
      end
      if (in_valid_i && !in_stall_o) begin
        it.kind = operation_i;
        it.raw = raw_time_i;
        it.count = sample_count_i;
        it.offset = eval_offset_i;
        track_stamp(it);
        next_valid = 1'b0;
        send_gap = send_gaps_on ? pick_gap() : 0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_stamps.size() != 0) begin
          it = queued_stamps.pop_front();
          operation_i <= it.kind;
          raw_time_i <= it.raw;
          sample_count_i <= it.count;
          eval_offset_i <= it.offset;
          next_valid = 1'b1;
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // Receiver back-pressure: random runs of stall and flow, plus a long hold-off whenever
  // the stimulus process flips hold_req. During a hold-off the block cannot hand over its
  // result, so it has to stall the input while the driver keeps offering.
  always @(posedge clk_i) begin : result_backpressure
    logic next_stall;
    next_stall = out_stall_i;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else if (!recv_gaps_on) begin
      next_stall = 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (out_stall_i) begin
      next_stall = 1'b0;
      stall_run = $urandom_range(0, 8);
    end else if ($urandom_range(0, 3) == 0) begin
      next_stall = 1'b1;
      stall_run = pick_gap();
    end else begin
      stall_run = $urandom_range(0, 6);
    end
    out_stall_i <= next_stall;
  end

  // Monitor: every handed-over estimate must match the oldest one we predicted.
  always @(posedge clk_i) begin : estimate_monitor
    logic [TIME_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (due_estimates.size() == 0) begin
        report_mismatch("time_estimate with nothing pending", '0, time_estimate_o);
      end else begin
        want = due_estimates.pop_front();
        if (time_estimate_o !== want) begin
          report_mismatch("time_estimate", want, time_estimate_o);
        end
      end
    end
  end

  // Configuration writes go out back to back; the model copy is updated alongside, which is
  // safe because the block is idle whenever this runs.
  task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    case (index)
      CFG_PROP_GAIN: phase_gain = value[GAIN_W-1:0];
      CFG_FREQ_GAIN: freq_gain = value[GAIN_W-1:0];
      CFG_NOM_PER:   period_est = value[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
    @(negedge clk_i);
  endtask

  // Waits until every item is taken and every estimate has come back, then lets any
  // result-less item still in the block finish.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (queued_stamps.size() != 0 || in_valid_i || due_estimates.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One random phase: a restart, then mostly a plausible capture stream (times advancing by
  // the true period times the sample count, plus jitter) mixed with evaluates, stray
  // restarts, and fully random items of any code.
  task automatic queue_phase(input int n_items, input logic [PERIOD_W-1:0] true_period);
    logic [TIME_W-1:0]   ideal;
    logic [SCOUNT_W-1:0] count;
    int                  r, jit;
    ideal = {8'd0, 32'($urandom), 24'd0};
    queue_stamp(OP_RESTART, {$urandom, $urandom}, SCOUNT_W'($urandom), $urandom);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        queue_stamp(OP_RESTART, {$urandom, $urandom}, SCOUNT_W'($urandom), $urandom);
      end else if (r < 20) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_stamp(OP_EVAL, {$urandom, $urandom}, SCOUNT_W'($urandom),
                      $urandom_range(0, 131072) - 65536);
        end else begin
          queue_stamp(OP_EVAL, {$urandom, $urandom}, SCOUNT_W'($urandom), $urandom);
        end
      end else if (r < 28) begin
        queue_stamp(2'($urandom_range(0, 3)), {$urandom, $urandom}, SCOUNT_W'($urandom),
                    $urandom);
      end else begin
        case ($urandom_range(0, 19))
          0:       count = '0;
          1:       count = '1;
          2:       count = SCOUNT_W'($urandom);
          default: count = SCOUNT_W'($urandom_range(64, 4096));
        endcase
        ideal = ideal + scale_round({16'd0, true_period}, {16'd0, count},
                                    PERIOD_FRAC - TIME_FRAC);
        jit = $urandom_range(0, 131072) - 65536;
        queue_stamp(OP_UPDATE, ideal + {{32{jit[31]}}, jit}, count, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    logic [PERIOD_W-1:0] nominal, true_period;
    int                  rate;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: evaluates before any update see the cleared state, the unused
    // code is ignored, and the first update loads the time while a zero period leaves the
    // prediction where the estimate stands.
    queue_stamp(OP_EVAL, '0, '0, 32'h0000_0000);
    queue_stamp(OP_EVAL, '0, '0, 32'h7FFF_FFFF);
    queue_stamp(OP_EVAL, '1, '1, 32'h8000_0000);
    queue_stamp(OP_UNUSED, '1, '1, 32'hFFFF_FFFF);
    queue_stamp(OP_UPDATE, TIME_MAX, '0, '0);
    queue_stamp(OP_UPDATE, '0, '1, '0);
    queue_stamp(OP_EVAL, '0, '0, 32'h7FFF_FFFF);
    wait_drained();

    // Everything at full scale: push the prediction past the top of the time range, then
    // drive the period into both of its clamps, and extrapolate to both ends.
    write_reg(CFG_PROP_GAIN, 48'h0000_FFFF_FFFF);
    write_reg(CFG_FREQ_GAIN, 48'h0000_FFFF_FFFF);
    write_reg(CFG_NOM_PER, PERIOD_MAX[CFG_W-1:0]);
    close_writes();
    queue_stamp(OP_RESTART, '0, '0, '0);
    queue_stamp(OP_UPDATE, TIME_MAX - 64'd1000, '0, '0);
    queue_stamp(OP_UPDATE, TIME_MAX, '1, '0);
    queue_stamp(OP_UPDATE, '0, 16'd1, '0);
    queue_stamp(OP_EVAL, '0, '0, 32'h8000_0000);
    queue_stamp(OP_UPDATE, TIME_MAX, '1, '0);
    queue_stamp(OP_EVAL, '0, '0, 32'h7FFF_FFFF);
    queue_stamp(OP_EVAL, '0, '0, 32'h8000_0000);
    queue_stamp(OP_UNUSED, '0, '0, '0);
    queue_stamp(OP_RESTART, '1, '1, '1);
    queue_stamp(OP_UPDATE, 64'h0000_0000_0100_0000, '1, '0);
    queue_stamp(OP_EVAL, '0, '0, 32'hFFFF_FFFF);
    queue_stamp(OP_UPDATE, 64'h0000_0000_0200_0000, 16'd1, '0);
    wait_drained();

    // Random phases, each under its own loop setting. Gains cycle through zero, small,
    // arbitrary and full scale; two phases also force the period to its extremes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      rate = $urandom_range(8000, 192000);
      nominal = PERIOD_W'((64'd1 << PERIOD_FRAC) / rate);
      true_period = nominal + (nominal >> 14) - $urandom_range(0, 32'(nominal >> 13));
      case (p % 4)
        0:       write_reg(CFG_PROP_GAIN, '0);
        1:       write_reg(CFG_PROP_GAIN, CFG_W'($urandom_range(0, 1 << 26)));
        2:       write_reg(CFG_PROP_GAIN, {16'd0, 32'($urandom)});
        default: write_reg(CFG_PROP_GAIN, 48'h0000_FFFF_FFFF);
      endcase
      // One phase keeps the period and frequency gain left over from the phase before.
      if (p != 3) begin
        case ((p / 2) % 4)
          0:       write_reg(CFG_FREQ_GAIN, CFG_W'($urandom_range(0, 1 << 12)));
          1:       write_reg(CFG_FREQ_GAIN, '0);
          2:       write_reg(CFG_FREQ_GAIN, {16'd0, 32'($urandom)});
          default: write_reg(CFG_FREQ_GAIN, 48'h0000_FFFF_FFFF);
        endcase
        if (p == 5) begin
          write_reg(CFG_NOM_PER, '0);
        end else if (p == 6) begin
          write_reg(CFG_NOM_PER, PERIOD_MAX[CFG_W-1:0]);
        end else begin
          write_reg(CFG_NOM_PER, nominal);
        end
      end
      close_writes();
      // Phase 4 runs at full rate with no idling on either side.
      send_gaps_on = (p != 4);
      recv_gaps_on = (p != 4);
      if (p == 2 || p == 6) begin
        hold_req = ~hold_req;
      end
      queue_phase(PHASE_ITEMS, true_period);
      wait_drained();
    end

    $display("Checked %0d estimates from %0d update, %0d evaluate, %0d restart and %0d",
             n_results, n_updates, n_evals, n_restarts, n_unused);
    $display("ignored items under %0d loop settings; %0d prediction and %0d period %s",
             n_settings, n_pred_clamps, n_period_clamps, "clamps,");
    $display("%0d input stall cycles.", n_in_stalls);
    if (n_errors == 0 && due_estimates.size() == 0) begin
      $display("dll_timestamp_filter_unit test passed");
    end else begin
      $display("dll_timestamp_filter_unit test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item waiting out the longest gap and stall.
  initial begin : watchdog
    #6000000;
    $display("dll_timestamp_filter_unit test failed");
    $finish;
  end

endmodule
